>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/cssq_pkg.sv
// Package for the cos^2 series core: widths, constants, command types.
`default_nettype none

package cssq_pkg;

    // Field widths
    localparam int XW        = 24;  // argument, Q2.21
    localparam int TOLW      = 29;  // tolerance register, Q0.32
    localparam int CSW       = 32;  // result, Q2.29
    localparam int TUW       = 6;   // terms_used field

    // Datapath widths
    localparam int LW        = 24;  // multiplier limb
    localparam int PW        = 2 * LW;       // limb product
    localparam int MW        = 2 * LW;       // term magnitude, Q.40 (< 2^48 for |x| < 4)
    localparam int AW        = 4 * LW;       // full term product
    localparam int FRAC_BITS = 40;
    localparam int DW        = 55;           // dividend bits taken from the product
    localparam int DCW       = $clog2(DW);
    localparam int SW        = 53;           // signed sum, Q.40
    localparam int RND_BITS  = 11;           // Q.40 -> Q2.29
    localparam int QW        = SW - RND_BITS;
    localparam int TOL_SHIFT = 8;            // Q0.32 -> Q.40

    localparam logic [TOLW-1:0]      TOL_RESET = 29'd42950;
    localparam logic signed [SW-1:0] SUM_ONE   =
        {{(SW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SW-1:0] RND_HALF  =
        {{(SW - RND_BITS){1'b0}}, 1'b1, {(RND_BITS - 1){1'b0}}};
    localparam logic signed [CSW-1:0] CS_MAX   = {1'b0, {(CSW - 1){1'b1}}};
    localparam logic signed [CSW-1:0] CS_MIN   = {1'b1, {(CSW - 1){1'b0}}};

    // Operand select of the shared limb multiplier
    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_XX,
        MUL_PP0,
        MUL_PP1,
        MUL_PP2,
        MUL_PP3
    } mul_sel_t;

    // Accumulator operation on the registered limb product
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_MID,
        ACC_ADD_HIGH
    } acc_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     start;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     x2_load;
        logic     sum_upd;
        logic     div_load;
        logic     div_step;
        logic     m_load;
        logic     out_load;
        logic     out_nc;
    } cssq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/cssq_datapath.sv
// Datapath: shared limb multiplier, product accumulator, serial divider, sum and output.
`default_nettype none

module cssq_datapath
    import cssq_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [TOLW-1:0]        cfg_wdata,
    input  wire logic signed [XW-1:0]   x,
    input  wire cssq_cmd_t              cmd,
    input  wire logic [$clog2(MAX_TERMS+1)-1:0] term_cnt,
    output logic                        term_small,
    output logic signed [CSW-1:0]       cos_sq,
    output logic [TUW-1:0]              terms_used,
    output logic                        not_converged
);

    localparam int NW  = $clog2(MAX_TERMS + 1);
    localparam int DVW = 2 * (NW + 1);   // divisor (2n)(2n-1)

    logic [TOLW-1:0]        tol_reg;
    logic [XW-1:0]          absx_reg;
    logic [PW-1:0]          prod_reg;
    logic [MW-1:0]          m_reg;
    logic [MW-1:0]          f_reg;
    logic [AW-1:0]          acc_reg;
    logic [DVW-1:0]         dvs_reg;
    logic [DVW-1:0]         rem_reg;
    logic [DW-1:0]          quo_reg;
    logic signed [SW-1:0]   sum_reg;
    logic signed [CSW-1:0]  cos_sq_reg;
    logic [TUW-1:0]         terms_reg;
    logic                   nc_reg;

    logic [XW-1:0]          x_abs;
    logic [LW-1:0]          mul_a;
    logic [LW-1:0]          mul_b;
    logic [PW-1:0]          prod;
    logic [NW:0]            two_n;
    logic [NW:0]            two_n_m1;
    logic [DVW:0]           trial;
    logic [DVW:0]           trial_diff;
    logic signed [SW-1:0]   term_s;
    logic signed [SW-1:0]   sum_rnd;
    logic signed [QW-1:0]   q;
    logic signed [CSW-1:0]  sat;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    // Magnitude of the argument; -4.0 maps to 2^23, which still fits
    assign x_abs = x[XW-1] ? unsigned'(-x) : unsigned'(x);

    // Limb operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_XX:
            begin
                mul_a = absx_reg;
                mul_b = absx_reg;
            end
            MUL_PP0:
            begin
                mul_a = m_reg[LW-1:0];
                mul_b = f_reg[LW-1:0];
            end
            MUL_PP1:
            begin
                mul_a = m_reg[LW-1:0];
                mul_b = f_reg[MW-1:LW];
            end
            MUL_PP2:
            begin
                mul_a = m_reg[MW-1:LW];
                mul_b = f_reg[LW-1:0];
            end
            MUL_PP3:
            begin
                mul_a = m_reg[MW-1:LW];
                mul_b = f_reg[MW-1:LW];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Divisor (2n)(2n-1) for the current term number
    assign two_n    = {term_cnt, 1'b0};
    assign two_n_m1 = two_n - 1'b1;

    // One restoring division step
    assign trial      = {rem_reg, quo_reg[DW-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};

    // Signed term for the sum
    assign term_s = signed'(SW'(m_reg));

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        dvs_reg  <= DVW'(two_n) * DVW'(two_n_m1);

        if (cmd.start)
        begin
            absx_reg <= x_abs;
            sum_reg  <= SUM_ONE;
        end

        // x^2 is exact Q6.42; drop two bits for Q.40, keep 4x^2 as well
        if (cmd.x2_load)
        begin
            m_reg <= MW'(prod_reg >> 2);
            f_reg <= {prod_reg[PW-1:2], 2'b00};
        end
        else if (cmd.m_load)
        begin
            m_reg <= quo_reg[MW-1:0];
        end

        // Odd terms subtract, even terms add back
        if (cmd.sum_upd)
        begin
            if (term_cnt[0])
            begin
                sum_reg <= sum_reg - term_s;
            end
            else
            begin
                sum_reg <= sum_reg + term_s;
            end
        end

        case (cmd.acc_op)
            ACC_LOAD:     acc_reg <= AW'(prod_reg);
            ACC_ADD_MID:  acc_reg <= acc_reg + (AW'(prod_reg) << LW);
            ACC_ADD_HIGH: acc_reg <= acc_reg + (AW'(prod_reg) << (2 * LW));
            default:      acc_reg <= acc_reg;
        endcase

        // Product truncated to Q.40 becomes the dividend
        if (cmd.div_load)
        begin
            quo_reg <= acc_reg[FRAC_BITS +: DW];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial_diff[DVW])
            begin
                rem_reg <= trial_diff[DVW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DVW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            cos_sq_reg <= sat;
            terms_reg  <= TUW'(term_cnt);
            nc_reg     <= cmd.out_nc;
        end
    end

    // Convergence test against tolerance moved to Q.40
    assign term_small = (m_reg <= MW'({tol_reg, {TOL_SHIFT{1'b0}}}));

    // Round half up to Q2.29, then saturate
    assign sum_rnd = sum_reg + RND_HALF;
    assign q       = sum_rnd[SW-1:RND_BITS];

    always_comb
    begin
        if ((&q[QW-1:CSW-1]) || !(|q[QW-1:CSW-1]))
        begin
            sat = q[CSW-1:0];
        end
        else if (q[QW-1])
        begin
            sat = CS_MIN;
        end
        else
        begin
            sat = CS_MAX;
        end
    end

    assign cos_sq        = cos_sq_reg;
    assign terms_used    = terms_reg;
    assign not_converged = nc_reg;

endmodule

`default_nettype wire

>>> rtl/core/cssq_ctrl.sv
// Controller: sequences squaring, term products, division and output handoff.
`default_nettype none

module cssq_ctrl
    import cssq_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire logic                   term_small,
    output cssq_cmd_t                   cmd,
    output logic [$clog2(MAX_TERMS+1)-1:0] term_cnt
);

    localparam int NW = $clog2(MAX_TERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQW,
        S_ADD,
        S_MUL,
        S_DLOAD,
        S_DIV,
        S_MNEXT,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             nc_reg, nc_next;
    logic [2:0]       k_reg, k_next;
    logic [DCW-1:0]   dcnt_reg, dcnt_next;
    logic             out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        nc_next    = nc_reg;
        k_next     = k_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        out_valid_next = out_valid_reg & ~out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    n_next     = NW'(1);
                    nc_next    = 1'b0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.mul_sel = MUL_XX;
                state_next  = S_SQW;
            end
            S_SQW:
            begin
                cmd.x2_load = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                cmd.sum_upd = 1'b1;
                if (term_small)
                begin
                    state_next = S_FIN;
                end
                else if (n_reg >= NW'(MAX_TERMS))
                begin
                    nc_next    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    k_next     = '0;
                    state_next = S_MUL;
                end
            end
            // Four limb products, each accumulated in the cycle after its issue
            S_MUL:
            begin
                k_next = k_reg + 1'b1;
                case (k_reg)
                    3'd0:
                    begin
                        cmd.mul_sel = MUL_PP0;
                    end
                    3'd1:
                    begin
                        cmd.mul_sel = MUL_PP1;
                        cmd.acc_op  = ACC_LOAD;
                    end
                    3'd2:
                    begin
                        cmd.mul_sel = MUL_PP2;
                        cmd.acc_op  = ACC_ADD_MID;
                    end
                    3'd3:
                    begin
                        cmd.mul_sel = MUL_PP3;
                        cmd.acc_op  = ACC_ADD_MID;
                    end
                    default:
                    begin
                        cmd.acc_op = ACC_ADD_HIGH;
                        state_next = S_DLOAD;
                    end
                endcase
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                dcnt_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DCW'(DW - 1))
                begin
                    state_next = S_MNEXT;
                end
                else
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            S_MNEXT:
            begin
                cmd.m_load = 1'b1;
                state_next = S_ADD;
            end
            S_FIN:
            begin
                cmd.out_nc = nc_reg;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            nc_reg        <= 1'b0;
            k_reg         <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            nc_reg        <= nc_next;
            k_reg         <= k_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign term_cnt  = n_reg;

endmodule

`default_nettype wire

>>> rtl/core/cos_squared_series_core.sv
// Top level of the cos^2(x) power series core.
// Usage:
//   Input channel in_valid/in_ready carries one item: x, signed Q2.21.
//   Output channel out_valid/out_ready returns one item per input: cos_sq
//   (Q2.29, rounded, saturated), terms_used and not_converged.
//   cfg_we/cfg_wdata write the 29-bit tolerance (Q0.32); write only when idle.
// Terms: T = terms used, 1 to MAX_TERMS. Each term after the first needs four
//   24x24 limb products on the one shared multiplier plus a restoring divide of
//   the 55-bit dividend by (2n)(2n-1); the divide dominates.
// Throughput: one item in flight; the next item is taken once the result
//   has moved into the output register.
// Stall: a result waits in the output register while out_ready is low;
//   the next item is computed meanwhile and holds until that register frees.
// Reset: rst_n clears control and output valid; tolerance returns to 42950.
`default_nettype none

module cos_squared_series_core
    import cssq_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [TOLW-1:0]        cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [XW-1:0]   x,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [CSW-1:0]       cos_sq,
    output logic [TUW-1:0]              terms_used,
    output logic                        not_converged
);

    localparam int NW = $clog2(MAX_TERMS + 1);

    cssq_cmd_t       cmd;
    logic [NW-1:0]   term_cnt;
    logic            term_small;

    cssq_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .term_small (term_small),
        .cmd        (cmd),
        .term_cnt   (term_cnt)
    );

    cssq_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .x             (x),
        .cmd           (cmd),
        .term_cnt      (term_cnt),
        .term_small    (term_small),
        .cos_sq        (cos_sq),
        .terms_used    (terms_used),
        .not_converged (not_converged)
    );

endmodule

`default_nettype wire

>>> rtl/core/cssq_checker.sv
// Port-level checker for the cos^2 series core, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module cssq_checker
    import cssq_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic signed [CSW-1:0]  cos_sq,
    input  wire logic [TUW-1:0]         terms_used,
    input  wire logic                   not_converged
);

    // A stalled result item holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cos_sq) && $stable(terms_used) && $stable(not_converged))

    // After taking an item the core is not ready in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // The not-converged flag only comes with the full term count
    `ASSERT_IMP(a_nc_full_terms, clk, rst_n, out_valid && not_converged, terms_used == TUW'(MAX_TERMS))

    // At least one term is always used (count wraps only at 64)
    `ASSERT_IMP(a_terms_nonzero, clk, rst_n, out_valid && (MAX_TERMS < 64), terms_used != '0)

endmodule

bind cos_squared_series_core cssq_checker #(.MAX_TERMS(MAX_TERMS)) u_cssq_checker (.*);

`default_nettype wire
